### hw/rtl/e2c_pkg.sv
package e2c_pkg;

    localparam int unsigned DaysW  = 16;   // whole days since epoch fit below 2^16
    localparam int unsigned RemW   = 17;   // time of day, below 86400
    localparam int unsigned CntW   = 4;

    localparam logic [RemW-1:0]  SecsPerDay   = 17'd86400;
    localparam logic [RemW-1:0]  SecsPerHour  = 17'd3600;
    localparam logic [RemW-1:0]  SecsPerMin   = 17'd60;
    localparam logic [8:0]       DaysLeapYear = 9'd366;
    localparam logic [8:0]       DaysYear     = 9'd365;

    // reciprocals of 675, 225 and 15 scaled by 2^35, 2^21 and 2^14, rounded up;
    // exact over the shifted operand ranges (25, 13 and 10 bits)
    localparam logic [25:0]       RecipDay     = 26'd50903317;
    localparam logic [13:0]       RecipHour    = 14'd9321;
    localparam logic [10:0]       RecipMin     = 11'd1093;

    // epoch year 1970 expressed against the 2000 base, and its residues
    localparam logic signed [7:0] EpochYearOff = -8'sd30;
    localparam logic [1:0]        EpochMod4    = 2'd2;
    localparam logic [6:0]        EpochMod100  = 7'd70;
    localparam logic [8:0]        EpochMod400  = 9'd370;
    localparam logic [6:0]        LastMod100   = 7'd99;
    localparam logic [8:0]        LastMod400   = 9'd399;

    localparam logic [3:0]        MonthFeb     = 4'd1;
    localparam logic [3:0]        MonthDec     = 4'd11;

    // day count, then time-of-day remainder
    localparam logic [CntW-1:0]   StepDays     = 4'd0;
    localparam logic [CntW-1:0]   StepTod      = 4'd1;
    localparam logic [CntW-1:0]   DivLastStep  = StepTod;

    // hour quotient, hour remainder, minute quotient, minute remainder
    localparam logic [CntW-1:0]   StepHours    = 4'd0;
    localparam logic [CntW-1:0]   StepHourRem  = 4'd1;
    localparam logic [CntW-1:0]   StepMins     = 4'd2;
    localparam logic [CntW-1:0]   StepMinRem   = 4'd3;
    localparam logic [CntW-1:0]   HmsLastStep  = StepMinRem;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_YEAR,
        S_MONTH,
        S_OUT
    } t_state;

    typedef struct packed {
        logic            load;
        logic            div_step;
        logic            year_step;
        logic            hms_step;
        logic            month_step;
        logic [CntW-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } t_status;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd1:                      len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### hw/rtl/epoch_seconds_to_calendar_top.sv
// Seconds-since-1970 to Gregorian date and time of day.
// Input channel: i_in_valid / o_in_ready carry i_epoch_seconds (unsigned 32 bits).
// Output channel: o_out_valid / i_out_ready carry year (offset from 2000, signed),
// month (1..12), day (1..31), hours, minutes and seconds.
// One transaction at a time. After acceptance the block divides by 86400
// (reciprocal multiply for the day count, then the remainder), then walks
// the years from 1970 one per cycle while the time of day is split into
// hours and minutes alongside, then walks the months one per cycle. The
// next input is taken the cycle after the result is consumed.
// A stalled receiver holds the result stable on the output ports and keeps
// o_in_ready low until i_out_ready is seen.
// Synchronous active-low reset returns to idle with o_in_ready high and no
// result pending; any conversion in flight is dropped.
module epoch_seconds_to_calendar_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [31:0]       i_epoch_seconds,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic signed [7:0] o_year_offset,
    output logic [3:0]        o_month_number,
    output logic [4:0]        o_day_of_month,
    output logic [4:0]        o_hours,
    output logic [5:0]        o_minutes,
    output logic [5:0]        o_seconds
);

    e2c_pkg::t_cmd    cmd;
    e2c_pkg::t_status status;

    e2c_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    e2c_dp u_dp (
        .i_clk           (i_clk),
        .i_cmd           (cmd),
        .i_epoch_seconds (i_epoch_seconds),
        .o_status        (status),
        .o_year_offset   (o_year_offset),
        .o_month_number  (o_month_number),
        .o_day_of_month  (o_day_of_month),
        .o_hours         (o_hours),
        .o_minutes       (o_minutes),
        .o_seconds       (o_seconds)
    );

`ifndef ASSERT_OFF
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input accepted while a result is pending");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_out_valid)
        else $error("result raised before conversion ran");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_month_number >= 4'd1 && o_month_number <= 4'd12))
        else $error("month out of range");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hours <= 5'd23 && o_minutes <= 6'd59 && o_seconds <= 6'd59))
        else $error("time of day out of range");
`endif

endmodule

### hw/rtl/e2c_ctrl.sv
module e2c_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  e2c_pkg::t_status i_status,
    output e2c_pkg::t_cmd    o_cmd
);

    e2c_pkg::t_state                r_state, n_state;
    logic [e2c_pkg::CntW-1:0]       r_cnt, n_cnt;
    logic                           hms_busy;

    assign hms_busy = (r_cnt <= e2c_pkg::HmsLastStep);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= e2c_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            e2c_pkg::S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    n_state = e2c_pkg::S_DIV;
                end
            end
            e2c_pkg::S_DIV: begin
                if (r_cnt == e2c_pkg::DivLastStep) begin
                    n_state = e2c_pkg::S_YEAR;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            e2c_pkg::S_YEAR: begin
                // time-of-day split runs alongside the year walk
                if (hms_busy) begin
                    n_cnt = r_cnt + 1'b1;
                end else if (i_status.year_done) begin
                    n_state = e2c_pkg::S_MONTH;
                end
            end
            e2c_pkg::S_MONTH: begin
                if (i_status.month_done) begin
                    n_state = e2c_pkg::S_OUT;
                end
            end
            e2c_pkg::S_OUT: begin
                if (i_out_ready) begin
                    n_state = e2c_pkg::S_IDLE;
                end
            end
            default: n_state = e2c_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready       = 1'b0;
        o_out_valid      = 1'b0;
        o_cmd            = '0;
        o_cmd.idx        = r_cnt;
        unique case (r_state)
            e2c_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            e2c_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            e2c_pkg::S_YEAR: begin
                o_cmd.hms_step  = hms_busy;
                o_cmd.year_step = !i_status.year_done;
            end
            e2c_pkg::S_MONTH: begin
                o_cmd.month_step = !i_status.month_done;
            end
            e2c_pkg::S_OUT: begin
                o_out_valid = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

### hw/rtl/e2c_dp.sv
module e2c_dp (
    input  logic               i_clk,
    input  e2c_pkg::t_cmd      i_cmd,
    input  logic [31:0]        i_epoch_seconds,
    output e2c_pkg::t_status   o_status,
    output logic signed [7:0]  o_year_offset,
    output logic [3:0]         o_month_number,
    output logic [4:0]         o_day_of_month,
    output logic [4:0]         o_hours,
    output logic [5:0]         o_minutes,
    output logic [5:0]         o_seconds
);

    localparam int unsigned DW = e2c_pkg::DaysW;
    localparam int unsigned RW = e2c_pkg::RemW;

    logic [31:0]        r_dividend;
    logic [RW-1:0]      r_rem;
    logic [DW-1:0]      r_days;
    logic signed [7:0]  r_yoff;
    logic [1:0]         r_m4;
    logic [6:0]         r_m100;
    logic [8:0]         r_m400;
    logic [3:0]         r_mon;
    logic [4:0]         r_hours;
    logic [5:0]         r_mins;

    // seconds / 86400 taken as (seconds >> 7) / 675 by reciprocal, remainder next cycle
    logic [50:0]   day_q;
    logic [32:0]   day_secs;
    logic [31:0]   tod_full;

    always_comb begin
        day_q    = {26'd0, r_dividend[31:7]} * {25'd0, e2c_pkg::RecipDay};
        day_secs = {{(33-DW){1'b0}}, r_days} * {16'd0, e2c_pkg::SecsPerDay};
        tod_full = r_dividend - day_secs[31:0];
    end

    // calendar lengths
    logic          leap;
    logic [8:0]    ylen;
    logic [4:0]    mlen;

    always_comb begin
        leap = (r_m400 == '0) || ((r_m100 != '0) && (r_m4 == '0));
        ylen = leap ? e2c_pkg::DaysLeapYear : e2c_pkg::DaysYear;
        mlen = e2c_pkg::month_len(r_mon)
             + {4'd0, (r_mon == e2c_pkg::MonthFeb) && leap};
    end

    assign o_status.year_done  = (r_days < {{(DW-9){1'b0}}, ylen});
    assign o_status.month_done = (r_mon == e2c_pkg::MonthDec)
                              || (r_days < {{(DW-5){1'b0}}, mlen});

    // hours as (tod >> 4) / 225, minutes as (rem >> 2) / 15
    logic [26:0]   hr_q;
    logic [20:0]   mn_q;
    logic [RW-1:0] hr_secs;
    logic [RW-1:0] mn_secs;

    always_comb begin
        hr_q    = {14'd0, r_rem[RW-1:4]} * {13'd0, e2c_pkg::RecipHour};
        mn_q    = {11'd0, r_rem[11:2]} * {10'd0, e2c_pkg::RecipMin};
        hr_secs = {12'd0, r_hours} * e2c_pkg::SecsPerHour;
        mn_secs = {11'd0, r_mins} * e2c_pkg::SecsPerMin;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dividend <= i_epoch_seconds;
            r_rem      <= '0;
            r_days     <= '0;
            r_yoff     <= e2c_pkg::EpochYearOff;
            r_m4       <= e2c_pkg::EpochMod4;
            r_m100     <= e2c_pkg::EpochMod100;
            r_m400     <= e2c_pkg::EpochMod400;
            r_mon      <= '0;
            r_hours    <= '0;
            r_mins     <= '0;
        end else begin
            if (i_cmd.div_step) begin
                if (i_cmd.idx == e2c_pkg::StepDays) begin
                    r_days <= day_q[50:35];
                end else begin
                    r_rem  <= tod_full[RW-1:0];
                end
            end
            if (i_cmd.hms_step) begin
                unique case (i_cmd.idx)
                    e2c_pkg::StepHours:   r_hours <= hr_q[25:21];
                    e2c_pkg::StepHourRem: r_rem   <= r_rem - hr_secs;
                    e2c_pkg::StepMins:    r_mins  <= mn_q[19:14];
                    default:              r_rem   <= r_rem - mn_secs;
                endcase
            end
            if (i_cmd.year_step) begin
                r_days <= r_days - {{(DW-9){1'b0}}, ylen};
                r_yoff <= r_yoff + 8'sd1;
                r_m4   <= r_m4 + 2'd1;
                r_m100 <= (r_m100 == e2c_pkg::LastMod100) ? '0 : r_m100 + 7'd1;
                r_m400 <= (r_m400 == e2c_pkg::LastMod400) ? '0 : r_m400 + 9'd1;
            end
            if (i_cmd.month_step) begin
                r_days <= r_days - {{(DW-5){1'b0}}, mlen};
                r_mon  <= r_mon + 4'd1;
            end
        end
    end

    assign o_year_offset  = r_yoff;
    assign o_month_number = r_mon + 4'd1;
    assign o_day_of_month = r_days[4:0] + 5'd1;
    assign o_hours        = r_hours;
    assign o_minutes      = r_mins;
    assign o_seconds      = r_rem[5:0];

endmodule
